FILE: rtl/stxf_pkg.sv
// Package for the start/length/end frame checker.
// Holds the shared types, codes and widths; no dependencies.
package stxf_pkg;

    localparam int LENGTH_DIGITS = 4;   // length-field bytes, 1 to 4
    localparam int CNT_W         = 14;  // width of the length and byte counters
    localparam int SEEN_W        = 3;   // width of the length-field byte counter
    localparam int BYTE_W        = 8;
    localparam int CFG_IDX_W     = 1;

    localparam logic [BYTE_W-1:0] START_CODE_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'h03;
    localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_ZERO      = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE      = 8'h39;

    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 1'd1;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEAD = 2'd1,
        PH_DIGS = 2'd2,
        PH_BODY = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_GOOD     = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_OVERRUN  = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] echo_byte;
        logic              in_frame;
        logic              frame_end;
        t_status           frame_status;
    } t_result;

endpackage

FILE: rtl/stxf_parser.sv
// Frame parser: holds the framing state and builds the result of each byte.
// Depends on stxf_pkg.
module stxf_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [stxf_pkg::BYTE_W-1:0] i_byte,
    input  logic [stxf_pkg::BYTE_W-1:0] i_start_code,
    input  logic [stxf_pkg::BYTE_W-1:0] i_end_code,
    output stxf_pkg::t_result           o_result
);

    stxf_pkg::t_phase              r_phase,   n_phase;
    logic [stxf_pkg::SEEN_W-1:0]   r_seen,    n_seen;
    logic                          r_stopped, n_stopped;
    logic [stxf_pkg::CNT_W-1:0]    r_len,     n_len;
    logic [stxf_pkg::CNT_W-1:0]    r_cnt,     n_cnt;

    logic                          is_digit;
    logic [stxf_pkg::CNT_W-1:0]    len_x10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= stxf_pkg::PH_HUNT;
            r_seen    <= '0;
            r_stopped <= 1'b0;
            r_len     <= '0;
            r_cnt     <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_seen    <= n_seen;
            r_stopped <= n_stopped;
            r_len     <= n_len;
            r_cnt     <= n_cnt;
        end
    end

    assign is_digit = (i_byte >= stxf_pkg::CHAR_ZERO) && (i_byte <= stxf_pkg::CHAR_NINE);
    // Times ten as two shifts and an add; the value wraps to the counter width.
    assign len_x10  = (r_len << 3) + (r_len << 1);

    always_comb begin
        n_phase   = r_phase;
        n_seen    = r_seen;
        n_stopped = r_stopped;
        n_len     = r_len;
        n_cnt     = r_cnt;
        o_result.echo_byte    = i_byte;
        o_result.in_frame     = 1'b0;
        o_result.frame_end    = 1'b0;
        o_result.frame_status = stxf_pkg::ST_NONE;

        if (r_phase == stxf_pkg::PH_HUNT) begin
            if (i_byte == i_start_code) begin
                o_result.in_frame = 1'b1;
                n_phase   = stxf_pkg::PH_LEAD;
                n_seen    = '0;
                n_stopped = 1'b0;
                n_len     = '0;
                n_cnt     = stxf_pkg::CNT_W'(1);
            end
        end else begin
            o_result.in_frame = 1'b1;
            n_cnt = r_cnt + stxf_pkg::CNT_W'(1);
            if (i_byte == i_end_code) begin
                // The end code wins over length parsing once a frame is open.
                o_result.frame_end    = 1'b1;
                o_result.frame_status = (n_cnt == r_len) ? stxf_pkg::ST_GOOD
                                                         : stxf_pkg::ST_MISMATCH;
                n_phase = stxf_pkg::PH_HUNT;
            end else if (r_phase != stxf_pkg::PH_BODY) begin
                if (!r_stopped) begin
                    if (is_digit) begin
                        n_len   = len_x10 + stxf_pkg::CNT_W'(i_byte[3:0]);
                        n_phase = stxf_pkg::PH_DIGS;
                    end else if (!((i_byte == stxf_pkg::CHAR_SPACE) &&
                                   (r_phase == stxf_pkg::PH_LEAD))) begin
                        n_stopped = 1'b1;
                    end
                end
                n_seen = r_seen + stxf_pkg::SEEN_W'(1);
                if (n_seen >= stxf_pkg::SEEN_W'(stxf_pkg::LENGTH_DIGITS)) begin
                    n_phase = stxf_pkg::PH_BODY;
                    // A stated length already reached means the frame is overrun.
                    if (n_cnt >= n_len) begin
                        o_result.frame_end    = 1'b1;
                        o_result.frame_status = stxf_pkg::ST_OVERRUN;
                        n_phase = stxf_pkg::PH_HUNT;
                    end
                end
            end else if (n_cnt >= r_len) begin
                o_result.frame_end    = 1'b1;
                o_result.frame_status = stxf_pkg::ST_OVERRUN;
                n_phase = stxf_pkg::PH_HUNT;
            end
        end
    end

endmodule

FILE: rtl/stxf_out_reg.sv
// Result register for the frame checker's output stream.
// Depends on stxf_pkg.
module stxf_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  stxf_pkg::t_result i_result,
    input  logic              i_take,
    output logic              o_valid,
    output logic              o_free,
    output stxf_pkg::t_result o_result
);

    logic              r_valid;
    stxf_pkg::t_result r_result;

    // The slot is free when empty or when its beat leaves in this cycle.
    assign o_free   = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: rtl/stx_len_etx_frame_checker_core.sv
// Top level of the start/length/end frame checker: configuration registers,
// parser and result register. Depends on stxf_pkg, stxf_parser, stxf_out_reg.
//
//  Channel   Direction  Beat carries
//  s         in         one received byte
//  m         out        echoed byte, in-frame flag, frame end, status
//  cfg       in         register index and value (start or end code)
//
// One byte is accepted per cycle while the output register can take it; its
// result is in the output register in the next cycle.
// The output register sets the rate: a new byte is taken whenever the
// register is empty or its beat is being taken in the same cycle.
// Synchronous active-low reset returns to hunting with codes 0x02 and 0x03.
module stx_len_etx_frame_checker_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,   // [7:0] data_byte
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [7:0]                     o_m_tdata,   // [7:0] echo_byte
    output logic                           o_m_tlast,   // frame_end
    output logic [2:0]                     o_m_tuser,   // [0] in_frame, [2:1] frame_status
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [stxf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    logic [stxf_pkg::BYTE_W-1:0] r_start_code;
    logic [stxf_pkg::BYTE_W-1:0] r_end_code;
    logic                        s_accept;
    logic                        m_take;
    logic                        out_free;
    stxf_pkg::t_result           new_result;
    stxf_pkg::t_result           out_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code <= stxf_pkg::START_CODE_RST;
            r_end_code   <= stxf_pkg::END_CODE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                stxf_pkg::CFG_START_CODE: r_start_code <= i_cfg_data;
                stxf_pkg::CFG_END_CODE:   r_end_code   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign m_take     = o_m_tvalid && i_m_tready;
    assign o_s_tready = out_free;
    assign s_accept   = i_s_tvalid && out_free;

    stxf_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (s_accept),
        .i_byte       (i_s_tdata),
        .i_start_code (r_start_code),
        .i_end_code   (r_end_code),
        .o_result     (new_result)
    );

    stxf_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s_accept),
        .i_result (new_result),
        .i_take   (m_take),
        .o_valid  (o_m_tvalid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign o_m_tdata = out_result.echo_byte;
    assign o_m_tlast = out_result.frame_end;
    assign o_m_tuser = {out_result.frame_status, out_result.in_frame};

    // A status is only reported on the beat that closes a frame.
    a_status_on_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tuser[2:1] == stxf_pkg::ST_NONE)
        else $error("status reported without frame end");

    // A closing beat always belongs to a frame and carries a status.
    a_end_in_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[0] && (o_m_tuser[2:1] != stxf_pkg::ST_NONE))
        else $error("frame end outside a frame or without status");

    // Every accepted byte produces a result beat in the next cycle.
    a_accept_to_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted byte lost");

endmodule
